>>> rtl/swdd_pkg.sv
// ----------------------------------------------------------------------------
// swdd_pkg
// Shared types and codes for the stack with delete at depth.
// ----------------------------------------------------------------------------
package swdd_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned POS_W  = 8;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_DELETE = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // one-hot sequencer states
  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_SHIFT = 2'b10
  } state_t;

  typedef struct packed {
    logic                we;
    logic                re;
    logic [WORD_W-1:0]   wdata;
  } ram_ctl_t;

endpackage

>>> rtl/swdd_ram.sv
// ----------------------------------------------------------------------------
// swdd_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module swdd_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                      clk,
  input  swdd_pkg::ram_ctl_t        ctl,
  input  logic [AW-1:0]             waddr,
  input  logic [AW-1:0]             raddr,
  output logic [swdd_pkg::WORD_W-1:0] rdata
);

  logic [swdd_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= ctl.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/stack_with_delete_at_depth.sv
// ----------------------------------------------------------------------------
// stack_with_delete_at_depth
// Bounded LIFO of signed 32-bit words with push, pop and delete at depth.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------
//  command  | start / busy       | opcode, value, position
//  result   | done (one cycle)   | popped_value, status, entry_count
//
//  an item is taken at an edge with start high and busy low; its result
//  shows with done in the next cycle for push, pop, bad delete and no-op
//  a valid delete at position p shifts p entries through the ram write and
//  read ports, one entry a cycle, busy all the while; done follows the shift
//  push and pop never raise busy, so they may come every cycle while no delete shifts
//  rst is synchronous and clears the count, done and the sequencer; the
//  store has no reset; results cannot be held off by the receiver
//
module stack_with_delete_at_depth #(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           opcode,
  input  logic signed [swdd_pkg::WORD_W-1:0]   value,
  input  logic [swdd_pkg::POS_W-1:0]           position,
  output logic                                 done,
  output logic signed [swdd_pkg::WORD_W-1:0]   popped_value,
  output logic [1:0]                           status,
  output logic [$clog2(STACK_DEPTH+1)-1:0]     entry_count
);

  localparam int unsigned CW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW   = $clog2(STACK_DEPTH);
  localparam int unsigned CMPW = (CW > swdd_pkg::POS_W) ? CW : swdd_pkg::POS_W;

  swdd_pkg::state_t              state;
  logic [CW-1:0]                 count;
  logic [AW-1:0]                 shift_addr;   // entry written in the next shift cycle
  logic [swdd_pkg::POS_W-1:0]    shift_left;   // writes still to do
  logic                          pop_sel;      // result word comes from the ram
  logic [swdd_pkg::WORD_W-1:0]   popped;
  swdd_pkg::status_t             result_status;

  logic                          done_next;
  logic                          pop_sel_next;
  logic [swdd_pkg::WORD_W-1:0]   popped_next;
  swdd_pkg::status_t             status_next;

  swdd_pkg::ram_ctl_t            ram_ctl;
  logic [AW-1:0]                 ram_waddr;
  logic [AW-1:0]                 ram_raddr;
  logic [swdd_pkg::WORD_W-1:0]   ram_rdata;

  logic                          accept;
  logic                          is_full;
  logic                          is_empty;
  logic                          del_ok;
  logic [CMPW-1:0]               pos_w;
  logic [CMPW-1:0]               cnt_w;
  logic [CMPW-1:0]               del_idx;
  logic [CW-1:0]                 cnt_m1;

  swdd_ram #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .ctl   (ram_ctl),
    .waddr (ram_waddr),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---- decode ---------------------------------------------------------------
  assign busy     = (state == swdd_pkg::S_SHIFT);
  assign accept   = start && (state == swdd_pkg::S_IDLE);
  assign is_full  = (count == CW'(STACK_DEPTH));
  assign is_empty = (count == '0);
  assign cnt_m1   = count - CW'(1);
  assign pos_w    = CMPW'(position);
  assign cnt_w    = CMPW'(count);
  // legal delete: 1 <= position < count
  assign del_ok   = (pos_w != '0) && (pos_w < cnt_w);
  // index of the entry removed, counted from the bottom
  assign del_idx  = cnt_w - CMPW'(1) - pos_w;

  // result strobe: last shift cycle, or any accepted item except a legal delete
  assign done_next = busy ? (shift_left == swdd_pkg::POS_W'(1))
                          : (accept && !((opcode == swdd_pkg::OP_DELETE) && del_ok));

  // ---- ram port steering ----------------------------------------------------
  always_comb begin
    ram_ctl.we    = 1'b0;
    ram_ctl.re    = 1'b0;
    ram_ctl.wdata = value;
    ram_waddr     = count[AW-1:0];
    ram_raddr     = cnt_m1[AW-1:0];
    if (state == swdd_pkg::S_SHIFT) begin
      // move entry k+1 (read last cycle) down to k, fetch k+2
      ram_ctl.we    = 1'b1;
      ram_ctl.re    = 1'b1;
      ram_ctl.wdata = ram_rdata;
      ram_waddr     = shift_addr;
      ram_raddr     = shift_addr + AW'(2);
    end else if (accept) begin
      case (opcode)
        swdd_pkg::OP_PUSH: begin
          ram_ctl.we = !is_full;
        end
        swdd_pkg::OP_POP: begin
          ram_ctl.re = !is_empty;
        end
        swdd_pkg::OP_DELETE: begin
          ram_ctl.re = del_ok;
          ram_raddr  = del_idx[AW-1:0] + AW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // ---- result payload of the item being accepted ----------------------------
  always_comb begin
    pop_sel_next = 1'b0;
    popped_next  = '0;
    status_next  = swdd_pkg::ST_OK;
    case (opcode)
      swdd_pkg::OP_PUSH: begin
        if (is_full) begin
          status_next = swdd_pkg::ST_FULL;
        end
      end
      swdd_pkg::OP_POP: begin
        if (is_empty) begin
          popped_next = '1;
          status_next = swdd_pkg::ST_EMPTY;
        end else begin
          pop_sel_next = 1'b1;
        end
      end
      swdd_pkg::OP_DELETE: begin
        if (!del_ok) begin
          status_next = swdd_pkg::ST_BADPOS;
        end
      end
      default: begin
      end
    endcase
  end

  // ---- sequencer and result registers ---------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swdd_pkg::S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= done_next;
      case (state)
        swdd_pkg::S_IDLE: begin
          if (accept) begin
            case (opcode)
              swdd_pkg::OP_PUSH: begin
                if (!is_full) begin
                  count <= count + CW'(1);
                end
              end
              swdd_pkg::OP_POP: begin
                if (!is_empty) begin
                  count <= cnt_m1;
                end
              end
              swdd_pkg::OP_DELETE: begin
                if (del_ok) begin
                  state <= swdd_pkg::S_SHIFT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        swdd_pkg::S_SHIFT: begin
          if (shift_left == swdd_pkg::POS_W'(1)) begin
            state <= swdd_pkg::S_IDLE;
            count <= cnt_m1;
          end
        end
        default: begin
          state <= swdd_pkg::S_IDLE;
        end
      endcase
    end
  end

  // payload side, no reset needed
  always_ff @(posedge clk) begin
    if (state == swdd_pkg::S_SHIFT) begin
      shift_addr <= shift_addr + AW'(1);
      shift_left <= shift_left - swdd_pkg::POS_W'(1);
    end else if (accept) begin
      shift_addr    <= del_idx[AW-1:0];
      shift_left    <= position;
      pop_sel       <= pop_sel_next;
      popped        <= popped_next;
      result_status <= status_next;
    end
  end

  // popped word of a non-empty pop comes straight from the ram read register
  assign popped_value = pop_sel ? $signed(ram_rdata) : $signed(popped);
  assign status       = result_status;
  assign entry_count  = count;

  // ---- assertions -----------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("entry count above capacity");

  a_quick_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode != swdd_pkg::OP_DELETE) |=> done)
    else $error("missing result one cycle after a non-delete item");

  a_shift_ends: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("shift finished without a result");

  a_no_result_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while a shift is running");

endmodule
